// ===== hdl/pdf_pkg.sv =====
package pdf_pkg;

	// sizing
	localparam int NUM_NODES = 1024;
	localparam int SET_DEPTH = 64;
	localparam int COST_W    = 31;
	localparam int NUM_DIMS  = 3;
	localparam int NODE_W    = 10;
	localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);
	localparam int VADDR_W   = NODE_W + IDX_W;
	localparam int VEC_DEPTH = 2 ** VADDR_W;
	localparam int VEC_W     = NUM_DIMS * COST_W;

	// stream packing
	localparam int IN_BITS    = NODE_W + 2 * NUM_DIMS * COST_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 5;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// config
	localparam int CFG_DATA_W = 10;
	localparam logic       CFG_NUM_OBJ   = 1'b0;
	localparam logic       CFG_GOAL_NODE = 1'b1;
	localparam logic [2:0] OBJ_THREE     = 3'd3;
	localparam logic [2:0] NUM_OBJ_RST   = 3'd3;
	localparam logic [NODE_W-1:0] GOAL_RST = '0;

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_GOAL = 2'd1,
		CAUSE_NODE = 2'd2
	} cause_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GCNT,
		ST_NCNT,
		ST_GSCAN,
		ST_NSCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                         action;
		logic [NODE_W-1:0]            node;
		logic [NUM_DIMS-1:0][COST_W-1:0] cost;
		logic [NUM_DIMS-1:0][COST_W-1:0] est;
	} item_t;

	typedef struct packed {
		logic   pruned;
		cause_t cause;
		logic   added;
		logic   overflow;
	} res_t;

	typedef struct packed {
		logic              re;
		logic [NODE_W-1:0] raddr;
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [CNT_W-1:0]  wdata;
	} cnt_req_t;

	typedef struct packed {
		logic               re;
		logic [VADDR_W-1:0] raddr;
		logic               we;
		logic [VADDR_W-1:0] waddr;
		logic [VEC_W-1:0]   wdata;
	} vec_req_t;

endpackage

// ===== hdl/pdf_count_mem.sv =====
module pdf_count_mem (
	input  logic                     clk,
	input  pdf_pkg::cnt_req_t        req,
	output logic [pdf_pkg::CNT_W-1:0] rdata
);
	import pdf_pkg::*;

	logic [CNT_W-1:0] mem [NUM_NODES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hdl/pdf_vec_mem.sv =====
module pdf_vec_mem (
	input  logic                     clk,
	input  pdf_pkg::vec_req_t        req,
	output logic [pdf_pkg::VEC_W-1:0] rdata
);
	import pdf_pkg::*;

	logic [VEC_W-1:0] mem [VEC_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hdl/pdf_ctrl.sv =====
module pdf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  pdf_pkg::item_t            item_in,
	input  logic [2:0]                num_obj,
	input  logic [pdf_pkg::NODE_W-1:0] goal,
	output pdf_pkg::cnt_req_t         cnt_req,
	input  logic [pdf_pkg::CNT_W-1:0] cnt_rdata,
	output pdf_pkg::vec_req_t         vec_req,
	input  logic [pdf_pkg::VEC_W-1:0] vec_rdata,
	output logic                      done,
	input  logic                      out_free,
	output pdf_pkg::res_t             res
);
	import pdf_pkg::*;

	state_t            state_q, state_d;
	logic [NODE_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  gcnt_q, gcnt_d;
	logic [CNT_W-1:0]  ncnt_q, ncnt_d;
	logic              vld_s1, vld_d;
	item_t             item_q, item_d;
	res_t              res_q, res_d;

	logic [NUM_DIMS-1:0][COST_W-1:0] vec;
	logic              cmp3;
	logic              hit;

	function automatic logic in_range(input logic [NODE_W-1:0] n);
		return 32'(n) < 32'(NUM_NODES);
	endfunction

	// stored vector no greater than x in every compared dim
	function automatic logic dominates(
		input logic [NUM_DIMS-1:0][COST_W-1:0] v,
		input logic [NUM_DIMS-1:0][COST_W-1:0] x,
		input logic                            use3
	);
		return (v[0] <= x[0]) && (v[1] <= x[1]) && (!use3 || (v[2] <= x[2]));
	endfunction

	assign vec  = vec_rdata;
	assign cmp3 = (num_obj != OBJ_THREE);
	assign res  = res_q;

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		idx_d      = idx_q;
		gcnt_d     = gcnt_q;
		ncnt_d     = ncnt_q;
		vld_d      = 1'b0;
		item_d     = item_q;
		res_d      = res_q;
		cnt_req    = '0;
		vec_req    = '0;
		item_ready = 1'b0;
		done       = 1'b0;
		hit        = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = clr_q;
				cnt_req.wdata = '0;
				clr_d         = clr_q + NODE_W'(1);
				if (clr_q == NODE_W'(NUM_NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					item_d        = item_in;
					cnt_req.re    = 1'b1;
					cnt_req.raddr = goal;
					state_d       = ST_GCNT;
				end
			end
			ST_GCNT: begin
				gcnt_d        = in_range(goal) ? cnt_rdata : '0;
				cnt_req.re    = 1'b1;
				cnt_req.raddr = item_q.node;
				idx_d         = '0;
				state_d       = ST_NCNT;
			end
			ST_NCNT: begin
				ncnt_d  = in_range(item_q.node) ? cnt_rdata : '0;
				state_d = ST_GSCAN;
			end
			ST_GSCAN: begin
				hit = vld_s1 && dominates(vec, item_q.est, cmp3);
				if (hit) begin
					res_d   = '{pruned: 1'b1, cause: CAUSE_GOAL, added: 1'b0, overflow: 1'b0};
					state_d = ST_DONE;
				end else if (idx_q < gcnt_q) begin
					vec_req.re    = 1'b1;
					vec_req.raddr = {goal, idx_q[IDX_W-1:0]};
					idx_d         = idx_q + CNT_W'(1);
					vld_d         = 1'b1;
				end else begin
					idx_d   = '0;
					state_d = ST_NSCAN;
				end
			end
			ST_NSCAN: begin
				hit = vld_s1 && dominates(vec, item_q.cost, cmp3);
				if (hit) begin
					res_d   = '{pruned: 1'b1, cause: CAUSE_NODE, added: 1'b0, overflow: 1'b0};
					state_d = ST_DONE;
				end else if (idx_q < ncnt_q) begin
					vec_req.re    = 1'b1;
					vec_req.raddr = {item_q.node, idx_q[IDX_W-1:0]};
					idx_d         = idx_q + CNT_W'(1);
					vld_d         = 1'b1;
				end else begin
					res_d   = '{pruned: 1'b0, cause: CAUSE_NONE, added: 1'b0, overflow: 1'b0};
					if (item_q.action) begin
						if (in_range(item_q.node) && (ncnt_q < CNT_W'(SET_DEPTH))) begin
							vec_req.we    = 1'b1;
							vec_req.waddr = {item_q.node, ncnt_q[IDX_W-1:0]};
							vec_req.wdata = item_q.cost;
							cnt_req.we    = 1'b1;
							cnt_req.waddr = item_q.node;
							cnt_req.wdata = ncnt_q + CNT_W'(1);
							res_d.added   = 1'b1;
						end else begin
							res_d.overflow = 1'b1;
						end
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			vld_s1  <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		gcnt_q <= gcnt_d;
		ncnt_q <= ncnt_d;
		item_q <= item_d;
		res_q  <= res_d;
	end

endmodule

// ===== hdl/pareto_dominance_filter.sv =====
// Pareto dominance filter for a multi-objective best-first search. Each input
// transfer names a node and carries a path-cost vector g and an estimate f; the
// block prunes it if some vector kept at the goal node is no greater than f, or
// else if some vector kept at the named node is no greater than g, comparing
// objectives 1..2 (1..3 unless num_objectives is 3). A check-and-add item that
// survives appends g to its node's set; a full set flags overflow instead. One
// result transfer follows every input transfer, in order. Items are handled one
// at a time: the scan walks the goal set and then the node set, stopping early
// on a hit, through the single read port of the vector memory, one stored entry
// per cycle. The next item can enter while the previous result still waits in
// the output register. After reset the per-node counts of all 1024 nodes are
// cleared in one pass during which no item is taken; configuration writes are
// taken at any time and must only be made while the block is idle.
module pareto_dominance_filter (
	input  logic                          clk,
	input  logic                          arst_n,

	// config write channel: index 0 num_objectives, index 1 goal_node
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [pdf_pkg::CFG_DATA_W-1:0] cfg_data,

	// items in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// node_index[9:0], cost_dim1..3, est_dim1..3 (31 b each), zero pad
	input  logic [pdf_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// action
	input  logic [0:0]                    s_axis_tuser,

	// results out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// pruned[0], prune_cause[2:1], added[3], overflow[4], zero pad
	output logic [pdf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import pdf_pkg::*;

	// config registers
	logic [2:0]        num_obj_q;
	logic [NODE_W-1:0] goal_q;

	// output register
	logic              out_full_q;
	res_t              out_q;

	item_t             item_in;
	cnt_req_t          cnt_req;
	vec_req_t          vec_req;
	logic [CNT_W-1:0]  cnt_rdata;
	logic [VEC_W-1:0]  vec_rdata;
	logic              done;
	logic              out_free;
	res_t              res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_obj_q <= NUM_OBJ_RST;
			goal_q    <= GOAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NUM_OBJ:   num_obj_q <= cfg_data[2:0];
				CFG_GOAL_NODE: goal_q    <= cfg_data[NODE_W-1:0];
				default:       ;
			endcase
		end
	end

	// unpack the input transfer
	always_comb begin
		item_in.action = s_axis_tuser[0];
		item_in.node   = s_axis_tdata[NODE_W-1:0];
		for (int d = 0; d < NUM_DIMS; d++) begin
			item_in.cost[d] = s_axis_tdata[NODE_W + d * COST_W +: COST_W];
			item_in.est[d]  = s_axis_tdata[NODE_W + (NUM_DIMS + d) * COST_W +: COST_W];
		end
	end

	// result register frees when empty or being drained this cycle
	assign out_free = !out_full_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (done && out_free) begin
			out_full_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_q.overflow, out_q.added,
		out_q.cause, out_q.pruned};

	pdf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_ready (s_axis_tready),
		.item_in    (item_in),
		.num_obj    (num_obj_q),
		.goal       (goal_q),
		.cnt_req    (cnt_req),
		.cnt_rdata  (cnt_rdata),
		.vec_req    (vec_req),
		.vec_rdata  (vec_rdata),
		.done       (done),
		.out_free   (out_free),
		.res        (res)
	);

	// per-node fill counts
	pdf_count_mem u_count_mem (
		.clk   (clk),
		.req   (cnt_req),
		.rdata (cnt_rdata)
	);

	// stored cost vectors, slot = {node, entry}
	pdf_vec_mem u_vec_mem (
		.clk   (clk),
		.req   (vec_req),
		.rdata (vec_rdata)
	);

endmodule
